>>> hw/rtl/dtfe_pkg.sv
// Package for the date/time field editor: key codes, cursor field codes,
// result record and calendar helpers. No dependencies.
`default_nettype none

package dtfe_pkg;

  typedef enum logic [2:0] {
    KEY_NONE   = 3'd0,
    KEY_OK     = 3'd1,
    KEY_LEFT   = 3'd2,
    KEY_RIGHT  = 3'd3,
    KEY_DOWN   = 3'd4,
    KEY_UP     = 3'd5,
    KEY_CANCEL = 3'd6,
    KEY_LOAD   = 3'd7
  } key_t;

  localparam logic [2:0] FIELD_YEAR   = 3'd0;
  localparam logic [2:0] FIELD_MONTH  = 3'd1;
  localparam logic [2:0] FIELD_DAY    = 3'd2;
  localparam logic [2:0] FIELD_HOUR   = 3'd3;
  localparam logic [2:0] FIELD_MINUTE = 3'd4;
  localparam logic [2:0] FIELD_LAST   = FIELD_MINUTE;

  localparam logic [13:0] YEAR_MAX    = 14'd9999;
  localparam logic [13:0] YEAR_RESET  = 14'd2000;
  localparam logic [3:0]  MONTH_MAX   = 4'd12;
  localparam logic [4:0]  DAY_MAX     = 5'd31;
  localparam logic [4:0]  HOUR_MAX    = 5'd23;
  localparam logic [5:0]  MINUTE_MAX  = 6'd59;

  // floor(y / 100) == (y * DIV100_RECIP) >> DIV100_SHIFT for y < 16384
  localparam logic [12:0] DIV100_RECIP = 13'd5243;
  localparam int          DIV100_SHIFT = 19;

  typedef struct packed {
    logic [13:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [2:0]  cursor;
    logic        commit;
    logic        leave;
  } result_t;

  function automatic logic leap_year(input logic [13:0] y);
    logic [26:0] prod;
    logic [7:0]  q;
    logic [13:0] q100;
    logic [13:0] r;
    prod = 27'(y) * 27'(DIV100_RECIP);
    q    = prod[DIV100_SHIFT+7:DIV100_SHIFT];
    q100 = {q, 6'b0} - {q, 6'b0} + 14'({q, 6'b0}) + 14'({q, 5'b0}) + 14'({q, 2'b0});
    r    = y - q100;
    return (y[1:0] == 2'b00) && ((r != 14'd0) || (q[1:0] == 2'b00));
  endfunction

  function automatic logic [4:0] month_days(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    case (m)
      4'd2:                      len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   len = 5'd30;
      default:                   len = DAY_MAX;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/date_time_field_editor_top.sv
// Date/time field editor top level: key event stream in, edited values out.
// Depends on dtfe_pkg.
//
// Usage:
//   Input channel s_axis: one transfer per key event. s_axis_tuser carries
//   the key code; s_axis_tdata carries the clock values used by a load key.
//   Output channel m_axis: exactly one transfer per input transfer, giving
//   year, month, day, hour, minute, cursor and the commit/leave pulses.
//   Each result is registered, in the output slot or, under a stall, in the skid register.
//   Throughput: one event per cycle while s_axis_tready is high; the edit
//   state is updated by a single registered pass per event.
//   Stall: when m_axis_tready is low the result holds; one further event is
//   taken into a skid register, then s_axis_tready drops until the output
//   drains.
//   Reset (rst, synchronous, active high): date 2000-01-01 00:00, cursor on
//   the year, no key held, both output slots empty.
`default_nettype none

module date_time_field_editor_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28], zero pad
  input  wire logic [39:0] s_axis_tdata,
  // cmd[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // year[13:0], month[17:14], day[22:18], hour[27:23], minute[33:28],
  // cursor[36:34], zero pad
  output logic [39:0]      m_axis_tdata,
  // commit[0], leave[1]
  output logic [1:0]       m_axis_tuser
);

  logic [13:0]   year;
  logic [3:0]    month;
  logic [4:0]    day;
  logic [4:0]    hour;
  logic [5:0]    minute;
  logic [2:0]    cursor;
  dtfe_pkg::key_t last_key;

  logic [13:0]   year_next;
  logic [3:0]    month_next;
  logic [4:0]    day_next;
  logic [4:0]    hour_next;
  logic [5:0]    minute_next;
  logic [2:0]    cursor_next;
  dtfe_pkg::key_t last_key_next;
  logic          commit_next;
  logic          leave_next;

  dtfe_pkg::result_t out_data;
  dtfe_pkg::result_t skid_data;
  dtfe_pkg::result_t res_next;
  logic              out_valid;
  logic              skid_valid;

  logic           accept;
  dtfe_pkg::key_t cmd;
  logic [13:0]    ld_year;
  logic [3:0]     ld_month;
  logic [4:0]     ld_day;
  logic [4:0]     ld_hour;
  logic [5:0]     ld_minute;

  assign s_axis_tready = !skid_valid;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cmd           = dtfe_pkg::key_t'(s_axis_tuser);
  assign ld_year       = s_axis_tdata[13:0];
  assign ld_month      = s_axis_tdata[17:14];
  assign ld_day        = s_axis_tdata[22:18];
  assign ld_hour       = s_axis_tdata[27:23];
  assign ld_minute     = s_axis_tdata[33:28];

  always_comb begin
    logic       up;
    logic       date_chg;
    logic [4:0] len;
    logic [13:0] y_sat;
    logic [3:0]  m_sat;
    year_next     = year;
    month_next    = month;
    day_next      = day;
    hour_next     = hour;
    minute_next   = minute;
    cursor_next   = cursor;
    last_key_next = last_key;
    commit_next   = 1'b0;
    leave_next    = 1'b0;
    up            = (cmd == dtfe_pkg::KEY_UP);
    date_chg      = 1'b0;
    len           = 5'd0;
    y_sat         = (ld_year > dtfe_pkg::YEAR_MAX) ? dtfe_pkg::YEAR_MAX : ld_year;
    m_sat         = (ld_month == 4'd0) ? 4'd1 :
                    (ld_month > dtfe_pkg::MONTH_MAX) ? dtfe_pkg::MONTH_MAX : ld_month;

    if (cmd == dtfe_pkg::KEY_NONE) begin
      last_key_next = dtfe_pkg::KEY_NONE;
    end else if (cmd == dtfe_pkg::KEY_LOAD) begin
      len           = dtfe_pkg::month_days(m_sat, dtfe_pkg::leap_year(y_sat));
      year_next     = y_sat;
      month_next    = m_sat;
      day_next      = (ld_day == 5'd0) ? 5'd1 : (ld_day > len) ? len : ld_day;
      hour_next     = (ld_hour > dtfe_pkg::HOUR_MAX) ? dtfe_pkg::HOUR_MAX : ld_hour;
      minute_next   = (ld_minute > dtfe_pkg::MINUTE_MAX) ? dtfe_pkg::MINUTE_MAX : ld_minute;
      cursor_next   = dtfe_pkg::FIELD_YEAR;
      last_key_next = dtfe_pkg::KEY_NONE;
    end else if (cmd != last_key) begin
      last_key_next = cmd;
      case (cmd)
        dtfe_pkg::KEY_OK:     commit_next = 1'b1;
        dtfe_pkg::KEY_CANCEL: leave_next  = 1'b1;
        dtfe_pkg::KEY_LEFT: begin
          cursor_next = (cursor == dtfe_pkg::FIELD_YEAR) ? dtfe_pkg::FIELD_LAST
                                                         : cursor - 3'd1;
        end
        dtfe_pkg::KEY_RIGHT: begin
          cursor_next = (cursor == dtfe_pkg::FIELD_LAST) ? dtfe_pkg::FIELD_YEAR
                                                         : cursor + 3'd1;
        end
        dtfe_pkg::KEY_UP, dtfe_pkg::KEY_DOWN: begin
          case (cursor)
            dtfe_pkg::FIELD_YEAR: begin
              date_chg  = 1'b1;
              year_next = up ? ((year == dtfe_pkg::YEAR_MAX) ? 14'd0 : year + 14'd1)
                             : ((year == 14'd0) ? dtfe_pkg::YEAR_MAX : year - 14'd1);
            end
            dtfe_pkg::FIELD_MONTH: begin
              date_chg   = 1'b1;
              month_next = up ? ((month == dtfe_pkg::MONTH_MAX) ? 4'd1 : month + 4'd1)
                              : ((month == 4'd1) ? dtfe_pkg::MONTH_MAX : month - 4'd1);
            end
            dtfe_pkg::FIELD_DAY: begin
              date_chg = 1'b1;
              day_next = up ? ((day == dtfe_pkg::DAY_MAX) ? 5'd1 : day + 5'd1)
                            : ((day == 5'd1) ? dtfe_pkg::DAY_MAX : day - 5'd1);
            end
            dtfe_pkg::FIELD_HOUR: begin
              hour_next = up ? ((hour == dtfe_pkg::HOUR_MAX) ? 5'd0 : hour + 5'd1)
                             : ((hour == 5'd0) ? dtfe_pkg::HOUR_MAX : hour - 5'd1);
            end
            dtfe_pkg::FIELD_MINUTE: begin
              minute_next = up ? ((minute == dtfe_pkg::MINUTE_MAX) ? 6'd0 : minute + 6'd1)
                               : ((minute == 6'd0) ? dtfe_pkg::MINUTE_MAX : minute - 6'd1);
            end
            default: ;
          endcase
          if (date_chg) begin
            len = dtfe_pkg::month_days(month_next, dtfe_pkg::leap_year(year_next));
            if (day_next > len) begin
              day_next = day_next - len;
            end
          end
        end
        default: ;
      endcase
    end

    res_next.year   = year_next;
    res_next.month  = month_next;
    res_next.day    = day_next;
    res_next.hour   = hour_next;
    res_next.minute = minute_next;
    res_next.cursor = cursor_next;
    res_next.commit = commit_next;
    res_next.leave  = leave_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      year     <= dtfe_pkg::YEAR_RESET;
      month    <= 4'd1;
      day      <= 5'd1;
      hour     <= 5'd0;
      minute   <= 6'd0;
      cursor   <= dtfe_pkg::FIELD_YEAR;
      last_key <= dtfe_pkg::KEY_NONE;
    end else if (accept) begin
      year     <= year_next;
      month    <= month_next;
      day      <= day_next;
      hour     <= hour_next;
      minute   <= minute_next;
      cursor   <= cursor_next;
      last_key <= last_key_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_axis_tready) begin
      out_valid  <= skid_valid || accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_axis_tready) begin
      out_data <= skid_valid ? skid_data : res_next;
    end else if (accept) begin
      skid_data <= res_next;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {3'b000, out_data.cursor, out_data.minute, out_data.hour,
                          out_data.day, out_data.month, out_data.year};
  assign m_axis_tuser  = {out_data.leave, out_data.commit};

endmodule

`default_nettype wire

>>> hw/rtl/dtfe_checker.sv
// Port-level checker for the date/time field editor, bound to its top level.
// Depends only on the ports of date_time_field_editor_top.
`default_nettype none

module dtfe_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [39:0] m_axis_tdata,
  input wire logic [1:0]  m_axis_tuser
);

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                        && $stable(m_axis_tuser))
    else $error("stalled transfer changed");

  a_one_pulse: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !(m_axis_tuser[0] && m_axis_tuser[1]))
    else $error("commit and leave together");

  a_fields_in_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tdata[36:34] <= 3'd4) && (m_axis_tdata[17:14] != 4'd0)
                      && (m_axis_tdata[17:14] <= 4'd12) && (m_axis_tdata[22:18] != 5'd0)
                      && (m_axis_tdata[13:0] <= 14'd9999))
    else $error("result field out of range");

  a_skid_depth: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input blocked with empty output");

endmodule

bind date_time_field_editor_top dtfe_checker u_dtfe_checker (.*);

`default_nettype wire
